/* rtl/core/crc_checked_frame_receiver_macros.svh */
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver_macros.svh
// Assertion helpers for the frame receiver RTL.
// ----------------------------------------------------------------------------
`ifndef CRC_CHECKED_FRAME_RECEIVER_MACROS_SVH
`define CRC_CHECKED_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, disabled in reset
`define CCFR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("ccfr assertion failed");

// next-cycle implication, disabled in reset
`define CCFR_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("ccfr assertion failed");

`endif

/* rtl/core/ccfr_pkg.sv */
// ----------------------------------------------------------------------------
// ccfr_pkg
// Types and constants shared by the CRC checked frame receiver.
// ----------------------------------------------------------------------------
package ccfr_pkg;

  localparam int CFG_ADDR_W = 3;

  localparam logic REG_SYNC_FIRST  = 1'b0;
  localparam logic REG_SYNC_SECOND = 1'b1;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [2:0] ROUTE_ERR       = 3'd4;
  localparam logic [3:0] GROUP_MAX       = 4'd3;
  localparam logic [7:0] ERR_UNKNOWN_CMD = 8'h01;

  typedef enum logic [3:0] {
    PH_SYNC0 = 4'd0,
    PH_SYNC1 = 4'd1,
    PH_LENL  = 4'd2,
    PH_LENH  = 4'd3,
    PH_SEQ   = 4'd4,
    PH_CMD   = 4'd5,
    PH_DATA  = 4'd6,
    PH_CRCL  = 4'd7,
    PH_CRCH  = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_READ,
    CTL_LOAD
  } ctl_t;

  typedef struct packed {
    logic start;
    logic restart;
  } crc_cmd_t;

endpackage

/* rtl/core/ccfr_ram.sv */
// ----------------------------------------------------------------------------
// ccfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ccfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  clk,
  wr_en,
  wr_addr,
  wr_data,
  rd_en,
  rd_addr,
  rd_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  input  logic             clk;
  input  logic             wr_en;
  input  logic [AW-1:0]    wr_addr;
  input  logic [WIDTH-1:0] wr_data;
  input  logic             rd_en;
  input  logic [AW-1:0]    rd_addr;
  output logic [WIDTH-1:0] rd_data;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/ccfr_crc_unit.sv */
// ----------------------------------------------------------------------------
// ccfr_crc_unit
// Bit-serial CRC-16/CCITT engine: one message bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module ccfr_crc_unit (
  input  logic               clk,
  input  logic               rst,
  input  ccfr_pkg::crc_cmd_t cmd,
  input  logic [7:0]         din,
  output logic [15:0]        crc,
  output logic               busy
);
  import ccfr_pkg::*;

  logic [15:0] crc_reg;
  logic [7:0]  shreg;
  logic [3:0]  bits_left;
  logic        fb;

  assign fb   = crc_reg[15] ^ shreg[7];
  assign crc  = crc_reg;
  assign busy = (bits_left != 4'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_left <= 4'd0;
    end else if (cmd.start) begin
      bits_left <= 4'd8;
    end else if (busy) begin
      bits_left <= bits_left - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      crc_reg <= cmd.restart ? CRC_INIT : crc_reg;
      shreg   <= din;
    end else if (busy) begin
      crc_reg <= {crc_reg[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      shreg   <= {shreg[6:0], 1'b0};
    end
  end

endmodule

/* rtl/core/crc_checked_frame_receiver.sv */
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver
// Sync/length framed packet receiver with CRC-16/CCITT check and replay.
// ----------------------------------------------------------------------------
// Takes one received byte per input beat. Sync, length and CRC bytes are
// taken directly; sequence, command and payload bytes feed a bit-serial CRC
// unit and stall the input while it works through the byte. A frame with a
// good CRC is replayed from the payload RAM, each result beat by a registered
// RAM read and then an output register load, held while out_stall is high; a
// frame with an unknown command or no payload gives a single beat with no RAM
// read. The input is stalled for the duration of the replay. The last result
// may still wait in the output register while the next byte is taken. No
// clearing pass after reset.
`include "crc_checked_frame_receiver_macros.svh"

module crc_checked_frame_receiver #(
  parameter int PAYLOAD_MAX = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      route,
  output logic [7:0]                      frame_seq,
  output logic [7:0]                      frame_cmd,
  output logic [6:0]                      frame_len,
  output logic                            has_byte,
  output logic [5:0]                      byte_index,
  output logic [7:0]                      payload_byte,
  output logic                            last,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ccfr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import ccfr_pkg::*;

  localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
  localparam logic [15:0] LEN_LIMIT = 16'(PAYLOAD_MAX);

  // configuration
  logic [7:0] sync_first;
  logic [7:0] sync_second;
  logic       cfg_wr;

  // control
  phase_t   phase, phase_next;
  ctl_t     ctl, ctl_next;
  crc_cmd_t crc_cmd;
  logic     crc_busy;
  logic [15:0] crc_val;

  // frame fields
  logic [7:0] len_lo;
  logic [6:0] len_q;
  logic [7:0] seq_q;
  logic [7:0] cmd_q;
  logic [6:0] cnt;
  logic [6:0] cnt_inc;
  logic [7:0] crc_lo;
  logic [15:0] len_word;

  // replay
  logic [5:0] rp_idx;
  logic       rp_err;
  logic       rp_empty;
  logic       rp_special;
  logic       rp_last;
  logic       out_free;
  logic       out_load;
  logic       in_acc;
  logic       crc_match;

  logic       ram_we;
  logic       ram_re;
  logic [7:0] ram_rd;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_SYNC_SECOND) ? {24'h0, sync_second} : {24'h0, sync_first};

  assign in_stall  = (ctl != CTL_IDLE) || crc_busy;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign len_word  = {rx_byte, len_lo};
  assign cnt_inc   = cnt + 7'd1;
  assign crc_match = ({rx_byte, crc_lo} == crc_val);

  assign rp_err     = (cmd_q[7:4] > GROUP_MAX);
  assign rp_empty   = (len_q == 7'd0);
  assign rp_special = rp_err || rp_empty;
  assign rp_last    = rp_special || ((7'(rp_idx) + 7'd1) == len_q);

  ccfr_crc_unit u_crc (
    .clk  (clk),
    .rst  (rst),
    .cmd  (crc_cmd),
    .din  (rx_byte),
    .crc  (crc_val),
    .busy (crc_busy)
  );

  ccfr_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_MAX)
  ) u_payload_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cnt[AW-1:0]),
    .wr_data (rx_byte),
    .rd_en   (ram_re),
    .rd_addr (rp_idx[AW-1:0]),
    .rd_data (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SYNC0;
      ctl         <= CTL_IDLE;
      out_valid   <= 1'b0;
      sync_first  <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
    end else begin
      phase <= phase_next;
      ctl   <= ctl_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr) begin
        if (paddr[2] == REG_SYNC_FIRST) begin
          sync_first <= pwdata[7:0];
        end else begin
          sync_second <= pwdata[7:0];
        end
      end
    end
  end

  always_comb begin
    phase_next = phase;
    ctl_next   = ctl;
    crc_cmd    = '0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    out_load   = 1'b0;

    if (in_acc) begin
      unique case (phase)
        PH_SYNC1: begin
          if (rx_byte == sync_second) begin
            phase_next = PH_LENL;
          end else if (rx_byte != sync_first) begin
            phase_next = PH_SYNC0;
          end
        end
        PH_LENL: phase_next = PH_LENH;
        PH_LENH: phase_next = (len_word > LEN_LIMIT) ? PH_SYNC0 : PH_SEQ;
        PH_SEQ: begin
          crc_cmd.start   = 1'b1;
          crc_cmd.restart = 1'b1;
          phase_next      = PH_CMD;
        end
        PH_CMD: begin
          crc_cmd.start = 1'b1;
          phase_next    = (len_q != 7'd0) ? PH_DATA : PH_CRCL;
        end
        PH_DATA: begin
          crc_cmd.start = 1'b1;
          ram_we        = 1'b1;
          if (cnt_inc >= len_q) begin
            phase_next = PH_CRCL;
          end
        end
        PH_CRCL: phase_next = PH_CRCH;
        PH_CRCH: begin
          phase_next = PH_SYNC0;
          if (crc_match) begin
            ctl_next = rp_special ? CTL_LOAD : CTL_READ;
          end
        end
        // hunting, and any unused phase code
        default: phase_next = (rx_byte == sync_first) ? PH_SYNC1 : PH_SYNC0;
      endcase
    end

    unique case (ctl)
      CTL_IDLE: ;
      CTL_READ: begin
        ram_re   = 1'b1;
        ctl_next = CTL_LOAD;
      end
      CTL_LOAD: begin
        if (out_free) begin
          out_load = 1'b1;
          ctl_next = rp_last ? CTL_IDLE : CTL_READ;
        end
      end
      default: ctl_next = CTL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      case (phase)
        PH_LENL: len_lo <= rx_byte;
        PH_LENH: len_q  <= len_word[6:0];
        PH_SEQ:  seq_q  <= rx_byte;
        PH_CMD: begin
          cmd_q <= rx_byte;
          cnt   <= 7'd0;
        end
        PH_DATA: cnt    <= cnt_inc;
        PH_CRCL: crc_lo <= rx_byte;
        PH_CRCH: rp_idx <= 6'd0;
        default: ;
      endcase
    end
    if (out_load) begin
      route        <= rp_err ? ROUTE_ERR : {1'b0, cmd_q[5:4]};
      frame_seq    <= seq_q;
      frame_cmd    <= cmd_q;
      frame_len    <= len_q;
      has_byte     <= rp_err || !rp_empty;
      byte_index   <= rp_special ? 6'd0 : rp_idx;
      payload_byte <= rp_err ? ERR_UNKNOWN_CMD : (rp_empty ? 8'h00 : ram_rd);
      last         <= rp_last;
      if (!rp_last) begin
        rp_idx <= rp_idx + 6'd1;
      end
    end
  end

  // replay never reads past the stored payload
  `CCFR_ASSERT_IMP(a_replay_idx, clk, rst, (ctl != CTL_IDLE) && !rp_special, (7'(rp_idx) < len_q))
  // the final data beat sits at the end of the payload
  `CCFR_ASSERT_IMP(a_last_index, clk, rst, out_valid && last && has_byte && (route != ROUTE_ERR), ((7'(byte_index) + 7'd1) == frame_len))
  // CRC unit only runs between sequence byte and CRC bytes
  `CCFR_ASSERT_IMP(a_crc_phase, clk, rst, crc_busy, (phase == PH_CMD) || (phase == PH_DATA) || (phase == PH_CRCL))
  // a bad CRC starts no replay and resumes the hunt
  `CCFR_ASSERT_NXT(a_bad_crc, clk, rst, in_acc && (phase == PH_CRCH) && !crc_match, (ctl == CTL_IDLE) && (phase == PH_SYNC0))

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CRC checked frame receiver.
// ----------------------------------------------------------------------------
// Streams framed byte traffic into the receiver: valid frames on every route,
// unknown commands, bad CRCs, oversize lengths and loose noise. Traffic runs
// under several sync byte settings. A local parser model predicts every
// replayed beat, and each beat is checked field by field. Both sides insert
// random idle cycles.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ccfr_pkg::*;

  localparam int PAYLOAD_MAX = 64;
  localparam int SETTLE      = 24;
  localparam int CYCLE_LIMIT = 600000;

  localparam logic [CFG_ADDR_W-1:0] ADDR_SYNC_FIRST  = {REG_SYNC_FIRST, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_SYNC_SECOND = {REG_SYNC_SECOND, 2'b00};

  typedef struct packed {
    logic [2:0] route;
    logic [7:0] seq;
    logic [7:0] cmd;
    logic [6:0] len;
    logic       has;
    logic [5:0] idx;
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            rx_byte = 8'h00;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            route;
  logic [7:0]            frame_seq;
  logic [7:0]            frame_cmd;
  logic [6:0]            frame_len;
  logic                  has_byte;
  logic [5:0]            byte_index;
  logic [7:0]            payload_byte;
  logic                  last;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  crc_checked_frame_receiver #(.PAYLOAD_MAX(PAYLOAD_MAX)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .route(route), .frame_seq(frame_seq), .frame_cmd(frame_cmd),
    .frame_len(frame_len), .has_byte(has_byte), .byte_index(byte_index),
    .payload_byte(payload_byte), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // parser model state
  logic [7:0]  cfg_sync_first  = SYNC_FIRST_RST;
  logic [7:0]  cfg_sync_second = SYNC_SECOND_RST;
  phase_t      rx_phase = PH_SYNC0;
  logic [15:0] rx_len = '0;
  logic [7:0]  rx_seq = '0;
  logic [7:0]  rx_cmd = '0;
  logic [7:0]  rx_store [PAYLOAD_MAX];
  logic [6:0]  rx_count = '0;
  logic [15:0] rx_crc = CRC_INIT;
  logic [15:0] rx_crc_seen = '0;

  frame_beat_t pending_beats[$];

  int  error_count = 0;
  int  bytes_sent = 0;
  int  beats_checked = 0;
  int  good_frames = 0;
  int  bad_crc_frames = 0;
  int  oversize_frames = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  send_idle_on = 1'b1;
  bit  recv_idle_on = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] crc16_ccitt_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  function automatic int draw_wait(bit enabled);
    if (!enabled) return 0;
    case ($urandom_range(0, 3))
      0, 1: return 0;
      2: return $urandom_range(1, 3);
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  function automatic void push_beat(logic [2:0] rt, logic has, logic [5:0] idx,
                                    logic [7:0] data, logic lst);
    frame_beat_t b;
    b.route = rt;
    b.seq   = rx_seq;
    b.cmd   = rx_cmd;
    b.len   = rx_len[6:0];
    b.has   = has;
    b.idx   = idx;
    b.data  = data;
    b.last  = lst;
    pending_beats.push_back(b);
  endfunction

  // advance the parser model by one accepted byte
  function automatic void predict_rx_byte(logic [7:0] b);
    logic [3:0] group;
    case (rx_phase)
      PH_SYNC1: begin
        if (b == cfg_sync_second) rx_phase = PH_LENL;
        else if (b != cfg_sync_first) rx_phase = PH_SYNC0;
      end
      PH_LENL: begin
        rx_len = {8'h00, b};
        rx_phase = PH_LENH;
      end
      PH_LENH: begin
        rx_len[15:8] = b;
        rx_phase = (rx_len > PAYLOAD_MAX) ? PH_SYNC0 : PH_SEQ;
      end
      PH_SEQ: begin
        rx_seq = b;
        rx_crc = crc16_ccitt_step(CRC_INIT, b);
        rx_phase = PH_CMD;
      end
      PH_CMD: begin
        rx_cmd = b;
        rx_crc = crc16_ccitt_step(rx_crc, b);
        rx_count = '0;
        rx_phase = (rx_len > 0) ? PH_DATA : PH_CRCL;
      end
      PH_DATA: begin
        rx_store[rx_count[5:0]] = b;
        rx_crc = crc16_ccitt_step(rx_crc, b);
        rx_count = rx_count + 7'd1;
        if (rx_count >= rx_len) rx_phase = PH_CRCL;
      end
      PH_CRCL: begin
        rx_crc_seen = {8'h00, b};
        rx_phase = PH_CRCH;
      end
      PH_CRCH: begin
        rx_crc_seen[15:8] = b;
        if (rx_crc_seen == rx_crc) begin
          group = rx_cmd[7:4];
          if (group > GROUP_MAX) begin
            push_beat(ROUTE_ERR, 1'b1, 6'd0, ERR_UNKNOWN_CMD, 1'b1);
          end else if (rx_len == 0) begin
            push_beat(group[2:0], 1'b0, 6'd0, 8'h00, 1'b1);
          end else begin
            for (int i = 0; i < rx_len; i++) begin
              push_beat(group[2:0], 1'b1, i[5:0], rx_store[i], (i + 1 == rx_len));
            end
          end
        end
        rx_phase = PH_SYNC0;
      end
      default: rx_phase = (b == cfg_sync_first) ? PH_SYNC1 : PH_SYNC0;
    endcase
  endfunction

  function automatic void check_field(string name, int exp, int act);
    if (exp != act) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp, act);
      error_count++;
    end
  endfunction

  // result side: check each beat, draw random stalls
  always @(posedge clk) begin
    frame_beat_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_beats.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual route %0d seq 0x%0h idx %0d",
                   $time, route, frame_seq, byte_index);
          error_count++;
        end else begin
          e = pending_beats.pop_front();
          check_field("route", e.route, route);
          check_field("frame_seq", e.seq, frame_seq);
          check_field("frame_cmd", e.cmd, frame_cmd);
          check_field("frame_len", e.len, frame_len);
          check_field("has_byte", e.has, has_byte);
          check_field("byte_index", e.idx, byte_index);
          check_field("payload_byte", e.data, payload_byte);
          check_field("last", e.last, last);
        end
        beats_checked++;
        stall_left = draw_wait(recv_idle_on);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected",
               cycle_count, pending_beats.size());
      $display("crc_checked_frame_receiver test failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_wait(send_idle_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    // a byte with no result may still be in the CRC unit
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_sync_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [7:0] exp);
    logic [31:0] rd;
    apb_access(1'b0, addr, 32'h0, rd);
    check_field("register readback", {24'h0, exp}, rd);
  endtask

  task automatic set_sync_bytes(input logic [7:0] first, input logic [7:0] second);
    logic [31:0] rd;
    wait_drained();
    apb_access(1'b1, ADDR_SYNC_FIRST, {24'h0, first}, rd);
    cfg_sync_first = first;
    apb_access(1'b1, ADDR_SYNC_SECOND, {24'h0, second}, rd);
    cfg_sync_second = second;
    read_sync_reg(ADDR_SYNC_FIRST, first);
    read_sync_reg(ADDR_SYNC_SECOND, second);
  endtask

  // full frame; a single flipped CRC bit makes it a bad one
  task automatic send_frame(input logic [7:0] seq, input logic [7:0] cmd,
                            input int len, input bit bad_crc);
    logic [7:0]  body[$];
    logic [15:0] crc;
    body = {seq, cmd};
    for (int i = 0; i < len; i++) body.push_back(8'($urandom));
    crc = CRC_INIT;
    foreach (body[i]) crc = crc16_ccitt_step(crc, body[i]);
    if (bad_crc) crc ^= 16'(1 << $urandom_range(0, 15));
    send_byte(cfg_sync_first);
    send_byte(cfg_sync_second);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    foreach (body[i]) send_byte(body[i]);
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
    if (bad_crc) bad_crc_frames++;
    else good_frames++;
  endtask

  task automatic send_oversize_header(input logic [15:0] len);
    send_byte(cfg_sync_first);
    send_byte(cfg_sync_second);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    oversize_frames++;
  endtask

  function automatic logic [7:0] random_cmd();
    logic [3:0] group;
    group = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(4, 15))
                                        : 4'($urandom_range(0, 3));
    return {group, 4'($urandom)};
  endfunction

  function automatic int random_len();
    case ($urandom_range(0, 19))
      0: return PAYLOAD_MAX;
      1, 2: return $urandom_range(7, PAYLOAD_MAX - 1);
      default: return $urandom_range(0, 6);
    endcase
  endfunction

  task test_register_reset();
    read_sync_reg(ADDR_SYNC_FIRST, SYNC_FIRST_RST);
    read_sync_reg(ADDR_SYNC_SECOND, SYNC_SECOND_RST);
  endtask

  task test_directed_frames();
    // repeated first sync byte while hunting, then an empty system frame
    send_byte(cfg_sync_first);
    send_frame(8'h00, 8'h00, 0, 1'b0);
    send_oversize_header(16'(PAYLOAD_MAX + 1));
    send_frame(8'hFF, 8'hFF, 0, 1'b0);
    send_frame(8'h5A, 8'h31, 0, 1'b1);
    // payload filling the whole buffer
    send_frame(8'h12, 8'h20, PAYLOAD_MAX, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_bytes);
    int stop_at;
    int room;
    int len;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 5) == 0) send_idle_on = !send_idle_on;
      if ($urandom_range(0, 5) == 0) recv_idle_on = !recv_idle_on;
      if ($urandom_range(0, 7) == 0) wait_drained();
      // trim the payload so the last frame stays close to the byte budget
      room = stop_at - bytes_sent - 6;
      len  = random_len();
      if (len > room) len = (room > 0) ? room : 0;
      case ($urandom_range(0, 19))
        0, 1: send_frame(8'($urandom), random_cmd(), len, 1'b1);
        2: send_oversize_header(16'($urandom_range(PAYLOAD_MAX + 1, 16'hFFFF)));
        3, 4, 5: begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end
        default: send_frame(8'($urandom), random_cmd(), len, 1'b0);
      endcase
    end
  endtask

  task test_sync_settings();
    logic [7:0] v;
    set_sync_bytes(8'h00, 8'hFF);
    test_random_traffic(25);
    set_sync_bytes(8'hFF, 8'h00);
    test_random_traffic(25);
    set_sync_bytes(8'($urandom), 8'($urandom));
    test_random_traffic(20);
    v = 8'($urandom);
    set_sync_bytes(v, v);
    test_random_traffic(20);
    set_sync_bytes(SYNC_FIRST_RST, SYNC_SECOND_RST);
    test_random_traffic(15);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_reset();
    test_directed_frames();
    test_random_traffic(60);
    test_sync_settings();
    wait_drained();
    $display("sent %0d bytes: %0d good frames, %0d bad CRC, %0d oversize, five sync settings",
             bytes_sent, good_frames, bad_crc_frames, oversize_frames);
    $display("checked %0d result beats, %0d mismatches", beats_checked, error_count);
    if (error_count == 0) begin
      $display("crc_checked_frame_receiver test passed");
    end else begin
      $display("crc_checked_frame_receiver test failed");
    end
    $finish;
  end

endmodule
